// ===== hw/rtl/pimon_pkg.sv =====
// ----------------------------------------------------------------------------
// pimon_pkg
// Types and constants shared by the power input event monitor modules.
// ----------------------------------------------------------------------------
package pimon_pkg;

   localparam int PinWidth    = 16;
   localparam int TimeWidth   = 32;
   localparam int FlagWidth   = 7;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDWidth   = 32;

   // Status flag bit positions
   localparam int FlagConfigured = 0;
   localparam int FlagGap        = 1;
   localparam int FlagCfgValid   = 2;
   localparam int FlagCfgError   = 3;
   localparam int FlagTick       = 4;
   localparam int FlagIrq        = 5;
   localparam int FlagSaturated  = 6;

   localparam logic [PinWidth-1:0]  PinMaskReset  = 16'hFFFF;
   localparam logic [PinWidth-1:0]  FaultMaskReset = 16'h0000;
   localparam logic [TimeWidth-1:0] GapLimitReset = 32'd5;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PIN_MASK   = 2'd0,
      CSR_FAULT_MASK = 2'd1,
      CSR_GAP_LIMIT  = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_OBSERVE = 1'b0,
      KIND_INIT    = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic                 kind;
      logic [TimeWidth-1:0] now_ms;
      logic [PinWidth-1:0]  pin_levels;
      logic [PinWidth-1:0]  pending_pins;
      logic                 periodic;
      logic                 pin_cfg_ok;
   } req_payload_type;

   typedef struct packed {
      logic                 active;
      logic [FlagWidth-1:0] status_flags;
      logic [TimeWidth-1:0] max_gap;
      logic [TimeWidth-1:0] interrupt_total;
      logic [TimeWidth-1:0] pin_history;
      logic [PinWidth-1:0]  last_levels;
      logic [TimeWidth-1:0] last_sample_ms;
      logic [TimeWidth-1:0] last_event_time;
   } rsp_payload_type;

   typedef struct packed {
      logic [PinWidth-1:0]  pin_mask;
      logic [PinWidth-1:0]  fault_mask;
      logic [TimeWidth-1:0] gap_limit_ms;
   } cfg_type;

endpackage

// ===== hw/rtl/pimon_csr.sv =====
// ----------------------------------------------------------------------------
// pimon_csr
// Configuration registers: pin mask, fault mask and gap limit.
// ----------------------------------------------------------------------------
module pimon_csr
   import pimon_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDWidth-1:0]   csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_PIN_MASK:   cfg_in.pin_mask     = csr_wdata[PinWidth-1:0];
            CSR_FAULT_MASK: cfg_in.fault_mask   = csr_wdata[PinWidth-1:0];
            CSR_GAP_LIMIT:  cfg_in.gap_limit_ms = csr_wdata[TimeWidth-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pin_mask     <= PinMaskReset;
         cfg_ff.fault_mask   <= FaultMaskReset;
         cfg_ff.gap_limit_ms <= GapLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/pimon_update.sv =====
// ----------------------------------------------------------------------------
// pimon_update
// Evidence record and its update for one sample, computed in one pass of combinational logic.
// ----------------------------------------------------------------------------
module pimon_update
   import pimon_pkg::*;
#(
   parameter int PIN_COUNT = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  req_payload_type item,
   input  cfg_type         cfg,
   output rsp_payload_type record_next
);

   localparam logic [PinWidth-1:0] PinSpan =
      PinWidth'((33'd1 << PIN_COUNT) - 33'd1);

   rsp_payload_type state_ff;
   rsp_payload_type state_in;

   rsp_payload_type      base;
   logic                 is_init;
   logic                 do_observe;
   logic [PinWidth-1:0]  pm;
   logic [PinWidth-1:0]  pend;
   logic                 tick;
   logic [TimeWidth-1:0] gap;
   logic [FlagWidth-1:0] flags;
   logic                 pin_change;

   always_comb begin
      is_init    = (item_kind_type'(item.kind) == KIND_INIT);
      do_observe = is_init || state_ff.active;
      pm         = cfg.pin_mask & PinSpan;

      // Initialize: start from a fresh record latched on this sample
      base = state_ff;
      if (is_init) begin
         base                 = '0;
         base.active          = 1'b1;
         base.status_flags    = '0;
         base.status_flags[FlagConfigured] = 1'b1;
         base.last_levels     = item.pin_levels;
         base.last_sample_ms  = item.now_ms;
         base.last_event_time = item.now_ms;
      end

      pend = is_init ? '0 : (item.pending_pins & pm);
      tick = is_init ? 1'b0 : item.periodic;
      gap  = item.now_ms - base.last_sample_ms;

      flags = base.status_flags;
      if (gap > cfg.gap_limit_ms) begin
         flags[FlagGap] = 1'b1;
      end
      if (item.pin_cfg_ok) begin
         flags[FlagCfgValid] = 1'b1;
      end else begin
         flags[FlagCfgValid] = 1'b0;
         flags[FlagCfgError] = 1'b1;
      end
      if (tick) begin
         flags[FlagTick] = 1'b1;
      end
      if (pend != '0) begin
         flags[FlagIrq] = 1'b1;
         if (base.interrupt_total == '1) begin
            flags[FlagSaturated] = 1'b1;
         end
      end

      pin_change = ((item.pin_levels ^ base.last_levels) & pm) != '0;

      state_in = state_ff;
      if (do_observe) begin
         state_in                 = base;
         state_in.status_flags    = flags;
         state_in.max_gap         = (gap > base.max_gap) ? gap : base.max_gap;
         if (pend != '0 && base.interrupt_total != '1) begin
            state_in.interrupt_total = base.interrupt_total + 1'b1;
         end
         state_in.pin_history     = base.pin_history
                                  | {16'h0000, (~item.pin_levels) & pm}
                                  | {16'h0000, pend & cfg.fault_mask}
                                  | {item.pin_levels & pm, 16'h0000};
         if (pend != '0 || pin_change) begin
            state_in.last_event_time = item.now_ms;
         end
         state_in.last_levels     = item.pin_levels;
         state_in.last_sample_ms  = item.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (load) begin
         state_ff <= state_in;
      end
   end

   assign record_next = state_in;

`ifndef SYNTH
   // Only an initialize sets the record active, and only reset drops it
   a_active_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |=> state_ff.active)
      else $error("record went inactive without reset");

   a_idle_flags: assert property (@(posedge clock) disable iff (reset)
      !state_ff.active |-> (state_ff.status_flags == '0))
      else $error("flags set on an inactive record");

   a_sat_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.status_flags[FlagSaturated] |-> (state_ff.interrupt_total == '1))
      else $error("saturated flag without a full count");

   a_configured: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> state_ff.status_flags[FlagConfigured])
      else $error("active record not marked configured");
`endif

endmodule

// ===== hw/rtl/power_input_event_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// power_input_event_monitor_unit
// Gathers evidence from power-status pin samples; one record per sample.
// ----------------------------------------------------------------------------
//  channel | ports                                   | role
//  --------+-----------------------------------------+---------------------------
//  req     | req_valid, req_ready, req_data          | sample or initialize in
//  rsp     | rsp_valid, rsp_ready, rsp_data          | full record out
//  csr     | csr_write_en, csr_index, csr_wdata      | register writes, no wait
//
//  One sample per cycle while rsp is not stalled; the record update is a single pass of compare, add
//  and OR logic between the input register and the result register.
//  rsp_valid rises when the record is loaded into the result register, after the
//  sample has passed the input register; the sample waits there while rsp is stalled.
//  Synchronous reset clears the record and handshake state and loads the CSR reset values.
//  A stalled rsp holds the result; req keeps taking samples while the input
//  register is empty or can move on in the same cycle.
// ----------------------------------------------------------------------------
module power_input_event_monitor_unit
   import pimon_pkg::*;
#(
   parameter int PIN_COUNT = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_write_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDWidth-1:0]   csr_wdata
);

   cfg_type         cfg;
   rsp_payload_type record_next;

   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_payload_type s1_data_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   logic            out_free;
   logic            advance;
   logic            req_xfer;

   pimon_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   pimon_update #(
      .PIN_COUNT (PIN_COUNT)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .item        (s1_data_ff),
      .cfg         (cfg),
      .record_next (record_next)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      advance   = s1_valid_ff && out_free;
      req_ready = !s1_valid_ff || out_free;
      req_xfer  = req_valid && req_ready;

      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: hold unless a transfer moves them
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= record_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for power_input_event_monitor_unit: a table of directed
// samples, then phases of random samples under different mask and gap-limit
// settings, with bursty req traffic and a stalling rsp side. Every returned
// record is compared field by field against a typed row's record or the predictor kept here.
// ----------------------------------------------------------------------------
module testbench;
   import pimon_pkg::*;

   localparam int ClockPeriod   = 12;
   localparam int TimeoutCycles = 400000;
   localparam int DirectedCount = 16;
   localparam int PhaseCount    = 6;
   localparam int PhaseSamples  = 215;
   localparam int HoldOffAt     = 540;
   localparam int HoldOffCycles = 400;
   localparam int PrintLimit    = 100;

   localparam logic [FlagWidth-1:0] InitFlagsOk =
      FlagWidth'((1 << FlagConfigured) | (1 << FlagCfgValid));
   localparam logic [FlagWidth-1:0] InitFlagsBad =
      FlagWidth'((1 << FlagConfigured) | (1 << FlagCfgError));
   localparam rsp_payload_type NoRecord = '0;

   typedef struct packed {
      req_payload_type sample;
      logic            typed;
      rsp_payload_type record;
   } directed_row_type;

   // sample: kind, now_ms, pin_levels, pending_pins, periodic, pin_cfg_ok
   // record: active, flags, max_gap, irq total, history, levels, sample, event
   directed_row_type directed_rows [DirectedCount] = '{
      // observe before initialize returns the cleared record
      {{KIND_OBSERVE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0}, 1'b1, NoRecord},
      {{KIND_INIT, 32'h0000_0000, 16'h0000, 16'h0000, 1'b0, 1'b1}, 1'b1,
       {1'b1, InitFlagsOk, 32'h0, 32'h0, 32'h0000_FFFF, 16'h0000, 32'h0, 32'h0}},
      {{KIND_OBSERVE, 32'h0000_0003, 16'h0000, 16'h0000, 1'b0, 1'b1}, 1'b0, NoRecord},
      {{KIND_OBSERVE, 32'h0000_0009, 16'hA5A5, 16'h0000, 1'b0, 1'b1}, 1'b0, NoRecord},
      {{KIND_OBSERVE, 32'h0000_0009, 16'hA5A5, 16'h0001, 1'b1, 1'b0}, 1'b0, NoRecord},
      {{KIND_OBSERVE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1}, 1'b0, NoRecord},
      // time wraps, gap of three
      {{KIND_OBSERVE, 32'h0000_0002, 16'hFFFF, 16'h0000, 1'b0, 1'b1}, 1'b0, NoRecord},
      // initialize while active: pending and tick are dropped
      {{KIND_INIT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0}, 1'b1,
       {1'b1, InitFlagsBad, 32'h0, 32'h0, 32'hFFFF_0000, 16'hFFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF}},
      {{KIND_OBSERVE, 32'h0000_0004, 16'h0000, 16'h8000, 1'b1, 1'b1}, 1'b0, NoRecord},
      {{KIND_OBSERVE, 32'h0000_000A, 16'h5A5A, 16'h0000, 1'b0, 1'b1}, 1'b0, NoRecord},
      {{KIND_OBSERVE, 32'h0000_0010, 16'h5A5A, 16'h0000, 1'b0, 1'b1}, 1'b0, NoRecord},
      {{KIND_INIT, 32'h8000_0000, 16'h5A5A, 16'h0000, 1'b0, 1'b1}, 1'b1,
       {1'b1, InitFlagsOk, 32'h0, 32'h0, 32'h5A5A_A5A5, 16'h5A5A, 32'h8000_0000,
        32'h8000_0000}},
      {{KIND_OBSERVE, 32'h8000_0000, 16'h5A5A, 16'h0000, 1'b0, 1'b1}, 1'b0, NoRecord},
      {{KIND_OBSERVE, 32'h8000_0005, 16'h5A5B, 16'h0000, 1'b0, 1'b1}, 1'b0, NoRecord},
      {{KIND_OBSERVE, 32'h7FFF_FFFF, 16'h5A5B, 16'h0F0F, 1'b1, 1'b0}, 1'b0, NoRecord},
      {{KIND_OBSERVE, 32'h7FFF_FFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b1}, 1'b0, NoRecord}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_payload_type        req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_payload_type        rsp_data;
   logic                   csr_write_en;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrDWidth-1:0]   csr_wdata;

   rsp_payload_type        record_state;
   cfg_type                csr_state;
   rsp_payload_type        records_due [$];
   int unsigned            mismatch_count;
   int unsigned            samples_accepted;
   logic [TimeWidth-1:0]   wall_ms;
   logic [PinWidth-1:0]    level_track;

   power_input_event_monitor_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #(ClockPeriod / 2);
      clock = 1'b0;
      #(ClockPeriod / 2);
   end

   // --- record predictor ---------------------------------------------------

   function automatic void observe_sample(input logic [TimeWidth-1:0] now,
                                          input logic [PinWidth-1:0]  levels,
                                          input logic [PinWidth-1:0]  pending,
                                          input logic                 tick,
                                          input logic                 cfg_ok);
      logic [PinWidth-1:0]  watched;
      logic [PinWidth-1:0]  pend;
      logic [TimeWidth-1:0] gap;
      watched = csr_state.pin_mask;
      gap = now - record_state.last_sample_ms;
      if (gap > record_state.max_gap) record_state.max_gap = gap;
      if (gap > csr_state.gap_limit_ms) record_state.status_flags[FlagGap] = 1'b1;
      if (cfg_ok) begin
         record_state.status_flags[FlagCfgValid] = 1'b1;
      end else begin
         record_state.status_flags[FlagCfgValid] = 1'b0;
         record_state.status_flags[FlagCfgError] = 1'b1;
      end
      if (tick) record_state.status_flags[FlagTick] = 1'b1;
      pend = pending & watched;
      if (pend != '0) begin
         record_state.status_flags[FlagIrq] = 1'b1;
         if (record_state.interrupt_total != '1) begin
            record_state.interrupt_total++;
         end else begin
            record_state.status_flags[FlagSaturated] = 1'b1;
         end
      end
      record_state.pin_history |= {levels & watched,
                                   (~levels & watched) | (pend & csr_state.fault_mask)};
      if (pend != '0 || ((levels ^ record_state.last_levels) & watched) != '0)
         record_state.last_event_time = now;
      record_state.last_levels    = levels;
      record_state.last_sample_ms = now;
   endfunction

   function automatic rsp_payload_type advance_record(input req_payload_type s);
      if (s.kind == KIND_INIT) begin
         record_state = '0;
         record_state.active = 1'b1;
         record_state.status_flags[FlagConfigured] = 1'b1;
         record_state.last_levels     = s.pin_levels;
         record_state.last_sample_ms  = s.now_ms;
         record_state.last_event_time = s.now_ms;
         observe_sample(s.now_ms, s.pin_levels, '0, 1'b0, s.pin_cfg_ok);
      end else if (record_state.active) begin
         observe_sample(s.now_ms, s.pin_levels, s.pending_pins, s.periodic, s.pin_cfg_ok);
      end
      return record_state;
   endfunction

   // --- stimulus -----------------------------------------------------------

   // Mostly short steps around the gap limit, sometimes long jumps and wraps.
   // The saturating interrupt count needs 2^32 interrupts and stays out of reach.
   function automatic req_payload_type random_sample();
      req_payload_type s;
      int unsigned     pick;
      s.kind = ($urandom_range(0, 39) == 0) ? KIND_INIT : KIND_OBSERVE;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         wall_ms += $urandom_range(0, 12);
      end else if (pick < 9) begin
         wall_ms += $urandom_range(0, 2000);
      end else begin
         wall_ms = $urandom();
      end
      s.now_ms = wall_ms;
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
         level_track = 16'($urandom());
      end else if (pick == 1) begin
         level_track ^= PinWidth'(1) << $urandom_range(0, PinWidth - 1);
      end
      s.pin_levels = level_track;
      pick = $urandom_range(0, 5);
      if (pick < 3) begin
         s.pending_pins = '0;
      end else if (pick == 3) begin
         s.pending_pins = PinWidth'(1) << $urandom_range(0, PinWidth - 1);
      end else if (pick == 4) begin
         s.pending_pins = 16'($urandom());
      end else begin
         s.pending_pins = '1;
      end
      s.periodic   = 1'($urandom_range(0, 1));
      s.pin_cfg_ok = ($urandom_range(0, 7) != 0);
      return s;
   endfunction

   // Hold the sample until the transfer, then log its table record if typed, else its predicted record.
   task automatic send_sample(input req_payload_type s, input logic typed,
                              input rsp_payload_type record);
      rsp_payload_type predicted;
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_record(s);
      records_due.push_back(typed ? record : predicted);
      samples_accepted++;
   endtask

   task automatic send_random_phase(input int count);
      int burst_left;
      int pause;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (pause != 0) begin
               req_valid <= 1'b0;
               repeat (pause) @(posedge clock);
            end
         end
         burst_left--;
         send_sample(random_sample(), 1'b0, NoRecord);
      end
   endtask

   task automatic drain_records();
      req_valid <= 1'b0;
      while (records_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_PIN_MASK;
      csr_wdata    <= {16'($urandom()), c.pin_mask};
      @(posedge clock);
      csr_index    <= CSR_FAULT_MASK;
      csr_wdata    <= {16'($urandom()), c.fault_mask};
      @(posedge clock);
      csr_index    <= CSR_GAP_LIMIT;
      csr_wdata    <= c.gap_limit_ms;
      @(posedge clock);
      csr_write_en <= 1'b0;
      csr_state = c;
   endtask

   initial begin : stimulus
      cfg_type settings;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_en     <= 1'b0;
      csr_index        <= CSR_PIN_MASK;
      csr_wdata        <= '0;
      record_state     = '0;
      csr_state        = {PinMaskReset, FaultMaskReset, GapLimitReset};
      mismatch_count   = 0;
      samples_accepted = 0;
      wall_ms          = '0;
      level_track      = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < DirectedCount; row++)
         send_sample(directed_rows[row].sample, directed_rows[row].typed,
                     directed_rows[row].record);
      drain_records();

      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: settings = {16'h0000, 16'hFFFF, 32'h0000_0000};
            1: settings = {16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF};
            2, 3: settings = {16'($urandom()), 16'($urandom()), 32'($urandom_range(0, 20))};
            4: settings = {16'hFFFF, 16'($urandom()), GapLimitReset};
            default: settings = {16'($urandom()), 16'($urandom()), 32'($urandom())};
         endcase
         apply_settings(settings);
         send_random_phase(PhaseSamples);
         drain_records();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // --- rsp side: stall pattern with one long hold-off ---------------------

   initial begin : rsp_stall_pattern
      int unsigned seg_left;
      int unsigned seg_mode;
      int unsigned hold_left;
      bit          held;
      seg_left  = 0;
      seg_mode  = 0;
      hold_left = 0;
      held      = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && samples_accepted >= HoldOffAt) begin
            held      = 1'b1;
            hold_left = HoldOffCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_mode = $urandom_range(0, 2);
               seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            case (seg_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // --- checking ------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PrintLimit)
         $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : record_check
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (records_due.size() == 0) begin
            report_mismatch("unexpected rsp transfer", 32'(rsp_data.last_sample_ms), '0);
         end else begin
            want = records_due.pop_front();
            if (rsp_data.active !== want.active)
               report_mismatch("active", 32'(rsp_data.active), 32'(want.active));
            if (rsp_data.status_flags !== want.status_flags)
               report_mismatch("status_flags", 32'(rsp_data.status_flags),
                               32'(want.status_flags));
            if (rsp_data.max_gap !== want.max_gap)
               report_mismatch("max_gap", rsp_data.max_gap, want.max_gap);
            if (rsp_data.interrupt_total !== want.interrupt_total)
               report_mismatch("interrupt_total", rsp_data.interrupt_total,
                               want.interrupt_total);
            if (rsp_data.pin_history !== want.pin_history)
               report_mismatch("pin_history", rsp_data.pin_history, want.pin_history);
            if (rsp_data.last_levels !== want.last_levels)
               report_mismatch("last_levels", 32'(rsp_data.last_levels),
                               32'(want.last_levels));
            if (rsp_data.last_sample_ms !== want.last_sample_ms)
               report_mismatch("last_sample_ms", rsp_data.last_sample_ms,
                               want.last_sample_ms);
            if (rsp_data.last_event_time !== want.last_event_time)
               report_mismatch("last_event_time", rsp_data.last_event_time,
                               want.last_event_time);
         end
      end
   end

   initial begin : watchdog
      #(TimeoutCycles * ClockPeriod);
      $display("FAILURE");
      $finish;
   end

endmodule
